### src/ttsp_pkg.sv
// ----------------------------------------------------------------------------
// ttsp_pkg
// Types, codes and constants shared by the text terminal stream processor.
// ----------------------------------------------------------------------------
package ttsp_pkg;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;

   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TILDE = 8'h7E;
   localparam logic [7:0] CHR_ESC   = 8'h1B;
   localparam logic [7:0] CHR_LBRK  = 8'h5B;
   localparam logic [7:0] CHR_SEMI  = 8'h3B;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_J     = 8'h4A;
   localparam logic [7:0] CHR_H     = 8'h48;
   localparam logic [7:0] CHR_K     = 8'h4B;
   localparam logic [7:0] CHR_M     = 8'h6D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_BS    = 8'h08;
   localparam logic [7:0] CHR_TAB   = 8'h09;

   localparam logic [1:0] PH_TEXT = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_CSI  = 2'd2;

   localparam logic [7:0] CSR_TEXT_FG  = 8'd0;
   localparam logic [7:0] CSR_TEXT_BG  = 8'd1;
   localparam logic [7:0] CSR_BLANK_FG = 8'd2;
   localparam logic [7:0] CSR_BLANK_BG = 8'd3;

   localparam logic [23:0] RST_TEXT_FG  = 24'hFFFFFF;
   localparam logic [23:0] RST_TEXT_BG  = 24'h000000;
   localparam logic [23:0] RST_BLANK_FG = 24'hFFFFFF;
   localparam logic [23:0] RST_BLANK_BG = 24'h000000;

   localparam logic REQ_STREAM = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       chunk_end;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [7:0]  cell_char;
      logic [23:0] cell_fg;
      logic [23:0] cell_bg;
      logic        read_error;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic [23:0] fg;
      logic [23:0] bg;
   } cell_type;

endpackage

### src/text_terminal_stream_processor.sv
// ----------------------------------------------------------------------------
// text_terminal_stream_processor
// Character-cell screen store with an ANSI escape subset, row ring for scroll.
// ----------------------------------------------------------------------------
// stream items and out-of-range reads: response registered on accept;
// in-range cell reads: the cell registered in rd_ff, the response in ST_READ,
// with req_ready low in ST_READ; one stream item per cycle while no row walk
// runs and the response is taken; the single screen ram write port sets the
// stall: scroll blanks the old top row, erase-line walks from the cursor to the
// line end, clear walks the whole screen; reset: synchronous, then a clearing pass
module text_terminal_stream_processor
   import ttsp_pkg::*;
#(
   parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [23:0]  csr_data
);

   localparam int DEPTH = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   localparam logic [6:0] LAST_COL = 7'(SCREEN_COLUMNS - 1);
   localparam logic [4:0] LAST_ROW = 5'(SCREEN_ROWS - 1);

   cell_type mem [DEPTH];
   cell_type rd_ff;

   logic [1:0]    state_ff, state_in;
   logic [6:0]    col_ff, col_in;
   logic [4:0]    row_ff, row_in;
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    val_ff, val_in;
   logic [4:0]    top_ff;
   logic [AW-1:0] sw_addr_ff, sw_end_ff;
   logic [23:0]   fill_fg_ff, fill_bg_ff;
   logic [23:0]   text_fg_ff, text_bg_ff, blank_fg_ff, blank_bg_ff;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   logic          accept, is_stream, rd_err;
   logic          wr_en, scroll, kclr, jclr;
   logic [4:0]    wr_row;
   logic [6:0]    wr_col;
   cell_type      wr_cell;
   logic [AW-1:0] wr_addr, rd_addr, k_addr, top_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   cell_type      mem_wdata;

   function automatic logic [4:0] phys(input logic [4:0] top, input logic [4:0] r);
      logic [5:0] s;
      s = {1'b0, top} + {1'b0, r};
      if (s >= 6'(SCREEN_ROWS)) begin
         s = s - 6'(SCREEN_ROWS);
      end
      return s[4:0];
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [4:0] prow, input logic [6:0] c);
      return AW'(32'(prow) * SCREEN_COLUMNS) + AW'(c);
   endfunction

   assign accept    = req_valid && req_ready;
   assign is_stream = (req_item.req_type == REQ_STREAM);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign rd_err  = (32'(req_item.read_row) >= SCREEN_ROWS) ||
                    (32'(req_item.read_col) >= SCREEN_COLUMNS);
   assign rd_addr = addr_of(phys(top_ff, req_item.read_row), req_item.read_col);
   assign wr_addr = addr_of(phys(top_ff, wr_row), wr_col);
   assign k_addr  = addr_of(phys(top_ff, row_ff), col_ff);
   assign top_addr = addr_of(top_ff, 7'd0);

   always_comb begin
      logic [7:0]  b;
      logic        text, plain, lf;
      logic [11:0] v;
      logic [7:0]  nt;
      b        = req_item.data_byte;
      text     = 1'b0;
      plain    = 1'b0;
      lf       = 1'b0;
      v        = '0;
      nt       = '0;
      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      val_in   = val_ff;
      wr_en    = 1'b0;
      wr_row   = row_ff;
      wr_col   = col_ff;
      wr_cell  = '{ch: CHR_SPACE, fg: blank_fg_ff, bg: blank_bg_ff};
      scroll   = 1'b0;
      kclr     = 1'b0;
      jclr     = 1'b0;
      if (is_stream) begin
         case (phase_ff)
            PH_ESC: begin
               if (b == CHR_LBRK) begin
                  phase_in = PH_CSI;
                  val_in   = '0;
               end else begin
                  phase_in = PH_TEXT;
                  text     = 1'b1;
               end
            end
            PH_CSI: begin
               if (b inside {[CHR_ZERO:CHR_NINE]}) begin
                  v = 12'(val_ff) * 12'd10 + 12'(b[3:0]);
                  val_in = (v > 12'd255) ? 8'd255 : v[7:0];
               end else if (b == CHR_SEMI) begin
                  val_in = val_ff;
               end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
                  phase_in = PH_TEXT;
                  if (b == CHR_J) begin
                     if (val_ff == 8'd2) begin
                        jclr   = 1'b1;
                        col_in = '0;
                        row_in = '0;
                     end
                  end else if (b == CHR_H) begin
                     col_in = '0;
                     row_in = '0;
                  end else if (b == CHR_K) begin
                     kclr = 1'b1;
                  end
               end else begin
                  phase_in = PH_TEXT;
                  text     = 1'b1;
               end
            end
            default: text = 1'b1;
         endcase
         if (text) begin
            if (b == CHR_ESC) begin
               phase_in = PH_ESC;
            end else begin
               plain = 1'b1;
            end
         end
         if (plain) begin
            case (b)
               CHR_LF: lf = 1'b1;
               CHR_CR: col_in = '0;
               CHR_BS: begin
                  if (col_ff != 7'd0) begin
                     col_in = col_ff - 7'd1;
                     wr_en  = 1'b1;
                     wr_col = col_ff - 7'd1;
                  end else if (row_ff != 5'd0) begin
                     row_in = row_ff - 5'd1;
                     col_in = LAST_COL;
                     wr_en  = 1'b1;
                     wr_row = row_ff - 5'd1;
                     wr_col = LAST_COL;
                  end
               end
               CHR_TAB: begin
                  nt = 8'({1'b0, col_ff[6:3]} + 5'd1) << 3;
                  col_in = (32'(nt) >= SCREEN_COLUMNS) ? LAST_COL : nt[6:0];
               end
               default: begin
                  if (b inside {[CHR_SPACE:CHR_TILDE]}) begin
                     wr_en   = 1'b1;
                     wr_cell = '{ch: b, fg: text_fg_ff, bg: text_bg_ff};
                     if (col_ff == LAST_COL) begin
                        lf = 1'b1;
                     end else begin
                        col_in = col_ff + 7'd1;
                     end
                  end
               end
            endcase
         end
         if (lf) begin
            col_in = '0;
            if (row_ff < LAST_ROW) begin
               row_in = row_ff + 5'd1;
            end else begin
               row_in = LAST_ROW;
               scroll = 1'b1;
            end
         end
         if (req_item.chunk_end) begin
            phase_in = PH_TEXT;
         end
      end
   end

   assign mem_we    = (state_ff == ST_SWEEP) || (accept && is_stream && wr_en);
   assign mem_waddr = (state_ff == ST_SWEEP) ? sw_addr_ff : wr_addr;
   assign mem_wdata = (state_ff == ST_SWEEP) ?
                      '{ch: CHR_SPACE, fg: fill_fg_ff, bg: fill_bg_ff} : wr_cell;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      if (state_ff == ST_SWEEP) begin
         if (sw_addr_ff == sw_end_ff) begin
            state_in = ST_IDLE;
         end
      end else if (state_ff == ST_READ) begin
         state_in = ST_IDLE;
      end else if (accept) begin
         if (is_stream) begin
            if (scroll || kclr || jclr) begin
               state_in = ST_SWEEP;
            end
         end else if (!rd_err) begin
            state_in = ST_READ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sw_addr_ff   <= '0;
         sw_end_ff    <= AW'(DEPTH - 1);
         fill_fg_ff   <= RST_BLANK_FG;
         fill_bg_ff   <= RST_BLANK_BG;
         top_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= PH_TEXT;
         val_ff       <= '0;
         text_fg_ff   <= RST_TEXT_FG;
         text_bg_ff   <= RST_TEXT_BG;
         blank_fg_ff  <= RST_BLANK_FG;
         blank_bg_ff  <= RST_BLANK_BG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEXT_FG:  text_fg_ff  <= csr_data;
               CSR_TEXT_BG:  text_bg_ff  <= csr_data;
               CSR_BLANK_FG: blank_fg_ff <= csr_data;
               CSR_BLANK_BG: blank_bg_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_SWEEP) begin
            sw_addr_ff <= sw_addr_ff + AW'(1);
         end
         if (state_ff == ST_READ) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= '{cursor_col: col_ff, cursor_row: row_ff, cell_char: rd_ff.ch,
                        cell_fg: rd_ff.fg, cell_bg: rd_ff.bg, read_error: 1'b0};
         end else if (accept && (is_stream || rd_err)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (is_stream) begin
               col_ff   <= col_in;
               row_ff   <= row_in;
               phase_ff <= phase_in;
               val_ff   <= val_in;
               fill_fg_ff <= blank_fg_ff;
               fill_bg_ff <= blank_bg_ff;
               if (scroll) begin
                  sw_addr_ff <= top_addr;
                  sw_end_ff  <= top_addr + AW'(SCREEN_COLUMNS - 1);
                  top_ff     <= (top_ff == LAST_ROW) ? 5'd0 : top_ff + 5'd1;
               end else if (kclr) begin
                  sw_addr_ff <= k_addr;
                  sw_end_ff  <= k_addr + AW'(LAST_COL - col_ff);
               end else if (jclr) begin
                  sw_addr_ff <= '0;
                  sw_end_ff  <= AW'(DEPTH - 1);
               end
               rsp_ff <= '{cursor_col: col_in, cursor_row: row_in, cell_char: 8'd0,
                           cell_fg: 24'd0, cell_bg: 24'd0, read_error: 1'b0};
            end else if (rd_err) begin
               rsp_ff <= '{cursor_col: col_ff, cursor_row: row_ff, cell_char: 8'd0,
                           cell_fg: 24'd0, cell_bg: 24'd0, read_error: 1'b1};
            end
         end
      end
   end

endmodule

### src/ttsp_checker.sv
// ----------------------------------------------------------------------------
// ttsp_checker
// Port-level checks on the result channel and on req_ready of the terminal stream processor.
// ----------------------------------------------------------------------------
module ttsp_checker
   import ttsp_pkg::*;
#(
   parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("response item dropped or changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.read_error |->
      rsp_item.cell_char == 8'd0 && rsp_item.cell_fg == 24'd0 && rsp_item.cell_bg == 24'd0)
      else $error("read error item carries cell data");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_item.cursor_col) < SCREEN_COLUMNS &&
                    32'(rsp_item.cursor_row) < SCREEN_ROWS)
      else $error("cursor outside screen");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready during clearing pass");

endmodule

bind text_terminal_stream_processor ttsp_checker #(
   .SCREEN_COLUMNS(SCREEN_COLUMNS),
   .SCREEN_ROWS(SCREEN_ROWS)
) u_ttsp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_item(rsp_item)
);
